// File: rtl/prime_field_add_sub_mul_256_macros.svh
// Assertion macros for the prime field arithmetic block.
// Used by the RTL files that carry concurrent checks; expects clk and rst in scope.
`ifndef PRIME_FIELD_ADD_SUB_MUL_256_MACROS_SVH
`define PRIME_FIELD_ADD_SUB_MUL_256_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define PFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PFA_ASSERT_NOW(label, ante, cons, msg)
`define PFA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/pfasm_pkg.sv
// Package for the prime field arithmetic block: operation codes and field constants.
// No dependencies.
`default_nettype none
package pfasm_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } op_t;

  localparam int FIELD_W = 256;

  // The prime p and its complement 2^256 - p.
  localparam logic [FIELD_W-1:0] PRIME_P = {
    64'hae20abd9d658967d, 64'h27b404db0b82d29f,
    64'h4797e0bbfb37d988, 64'h0000000000000001};
  localparam logic [FIELD_W-1:0] PRIME_COMP = {
    64'h51df542629a76982, 64'hd84bfb24f47d2d60,
    64'hb8681f4404c82677, 64'hffffffffffffffff};

  // The product reduction folds the lower half in one byte per stage.
  localparam int FOLD_BITS   = 8;
  localparam int FOLD_STAGES = FIELD_W / FOLD_BITS;

  typedef logic [2**FOLD_BITS-1:0][FIELD_W-1:0] fold_tbl_t;

  // Entry t holds t * 2^256 mod p, or that value plus 2^256 - p when add_comp is set.
  function automatic fold_tbl_t make_fold_tbl(logic add_comp);
    fold_tbl_t        tbl;
    logic [FIELD_W:0] v;
    v = '0;
    for (int t = 0; t < 2**FOLD_BITS; t++) begin
      tbl[t[FOLD_BITS-1:0]] = add_comp ? v[FIELD_W-1:0] + PRIME_COMP : v[FIELD_W-1:0];
      v = v + {1'b0, PRIME_COMP};
      if (v >= {1'b0, PRIME_P}) v = v - {1'b0, PRIME_P};
    end
    return tbl;
  endfunction

  localparam fold_tbl_t FOLD_TBL      = make_fold_tbl(1'b0);
  localparam fold_tbl_t FOLD_TBL_COMP = make_fold_tbl(1'b1);

endpackage
`default_nettype wire

// File: rtl/prime_field_add_sub_mul_256.sv
// Top level of the prime field add, subtract and multiply pipeline.
// Depends on pfasm_pkg and prime_field_add_sub_mul_256_macros.svh.
//
//   channel  | direction | tdata                         | tuser
//   s_axis   | in        | a limbs 0..3, b limbs 0..3    | operation
//   m_axis   | out       | result limbs 0..3             | -
//
// One item enters per cycle unless the output stalls; every item passes five multiply
// and sum stages, 32 stages that fold the lower half of the product into the upper
// half a byte at a time, and one final conditional subtract of p. Add and subtract
// ride the same stages. rst clears only the valid bits. When the output register holds
// an unaccepted transfer the whole pipeline holds, and s_axis_tready falls with it.
`default_nettype none
`include "prime_field_add_sub_mul_256_macros.svh"

module prime_field_add_sub_mul_256
  import pfasm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // a_limb0, a_limb1, a_limb2, a_limb3, b_limb0, b_limb1, b_limb2, b_limb3
  input  wire logic [511:0] s_axis_tdata,
  // operation
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_limb0, result_limb1, result_limb2, result_limb3
  output logic [255:0]      m_axis_tdata
);

  localparam int RED_STAGES = FOLD_STAGES;

  logic en;

  logic [FIELD_W-1:0] a_in, b_in;
  op_t op_in;

  assign a_in  = s_axis_tdata[255:0];
  assign b_in  = s_axis_tdata[511:256];
  assign op_in = op_t'(s_axis_tuser);

  // Stage 1: 32x32 partial products, raw sum and difference.
  logic              s1_valid;
  op_t               s1_op;
  logic [63:0]       s1_pp [8][8];
  logic [FIELD_W:0]  s1_sum, s1_diff;

  // Stage 2: row sums and finished add/sub result.
  logic              s2_valid;
  op_t               s2_op;
  logic [287:0]      s2_row [8];
  logic [FIELD_W-1:0] s2_res;
  logic [287:0]      row_next [8];
  logic [FIELD_W-1:0] res_next;

  // Stages 3 to 5: product sum tree.
  logic              s3_valid, s4_valid, s5_valid;
  op_t               s3_op, s4_op, s5_op;
  logic [319:0]      s3_q [4];
  logic [383:0]      s4_w [2];
  logic [511:0]      s5_prod;
  logic [FIELD_W-1:0] s3_res, s4_res, s5_res;

  // Fold stages: the first one starts from the upper half and the lower half.
  logic               r_valid [RED_STAGES];
  op_t                r_op    [RED_STAGES];
  logic [FIELD_W-1:0] r_acc   [RED_STAGES];
  logic [FIELD_W-1:0] r_lo    [RED_STAGES];
  logic [FIELD_W-1:0] acc0_next;
  logic [FIELD_W-1:0] lo0_next;

  // Output stage: final conditional subtract of p.
  logic               out_valid;
  op_t                out_op;
  logic [FIELD_W-1:0] out_res;
  logic [FIELD_W-1:0] out_next;

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      s4_valid   <= 1'b0;
      s5_valid   <= 1'b0;
    end else if (en) begin
      s1_valid   <= s_axis_tvalid;
      s2_valid   <= s1_valid;
      s3_valid   <= s2_valid;
      s4_valid   <= s3_valid;
      s5_valid   <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        for (int j = 0; j < 8; j++) begin
          s1_pp[i][j] <= 64'(a_in[32*i +: 32]) * 64'(b_in[32*j +: 32]);
        end
      end
      s1_sum  <= {1'b0, a_in} + {1'b0, b_in};
      s1_diff <= {1'b0, a_in} - {1'b0, b_in};
      s1_op   <= op_in;
    end
  end

  always_comb begin
    logic [255:0]     even_part, odd_part;
    logic [FIELD_W:0] sub_p;
    for (int i = 0; i < 8; i++) begin
      // Even and odd columns of a row do not overlap, so each is a plain concatenation.
      even_part   = {s1_pp[i][6], s1_pp[i][4], s1_pp[i][2], s1_pp[i][0]};
      odd_part    = {s1_pp[i][7], s1_pp[i][5], s1_pp[i][3], s1_pp[i][1]};
      row_next[i] = {32'd0, even_part} + {odd_part, 32'd0};
    end
    sub_p = {1'b0, s1_sum[FIELD_W-1:0]} - {1'b0, PRIME_P};
    case (s1_op)
      OP_ADD: begin
        if (s1_sum[FIELD_W]) begin
          res_next = s1_sum[FIELD_W-1:0] + PRIME_COMP;
        end else if (!sub_p[FIELD_W]) begin
          res_next = sub_p[FIELD_W-1:0];
        end else begin
          res_next = s1_sum[FIELD_W-1:0];
        end
      end
      OP_SUB: begin
        if (s1_diff[FIELD_W]) begin
          res_next = s1_diff[FIELD_W-1:0] - PRIME_COMP;
        end else begin
          res_next = s1_diff[FIELD_W-1:0];
        end
      end
      default: res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_row <= row_next;
      s2_res <= res_next;
      s2_op  <= s1_op;
      for (int m = 0; m < 4; m++) begin
        s3_q[m] <= {32'd0, s2_row[2*m]} + {s2_row[2*m+1], 32'd0};
      end
      s3_res <= s2_res;
      s3_op  <= s2_op;
      for (int n = 0; n < 2; n++) begin
        s4_w[n] <= {64'd0, s3_q[2*n]} + {s3_q[2*n+1], 64'd0};
      end
      s4_res  <= s3_res;
      s4_op   <= s3_op;
      s5_prod <= {128'd0, s4_w[0]} + {s4_w[1], 128'd0};
      s5_res  <= s4_res;
      s5_op   <= s4_op;
    end
  end

  always_comb begin
    if (s5_op == OP_MUL) begin
      acc0_next = s5_prod[511:256];
      lo0_next  = s5_prod[255:0];
    end else begin
      acc0_next = s5_res;
      lo0_next  = '0;
    end
  end

  for (genvar k = 0; k < RED_STAGES; k++) begin : g_red
    logic                 valid_in;
    op_t                  op_k;
    logic [FIELD_W-1:0]   acc_in, lo_in;
    logic [FOLD_BITS-1:0] top_bits;
    logic [FIELD_W-1:0]   low_part;
    logic [FIELD_W:0]     sum_plain, sum_comp;
    logic [FIELD_W-1:0]   acc_next;

    if (k == 0) begin : g_first
      assign valid_in = s5_valid;
      assign op_k     = s5_op;
      assign acc_in   = acc0_next;
      assign lo_in    = lo0_next;
    end else begin : g_next
      assign valid_in = r_valid[k-1];
      assign op_k     = r_op[k-1];
      assign acc_in   = r_acc[k-1];
      assign lo_in    = r_lo[k-1];
    end

    // The byte shifted out of the top comes back as its weight modulo p. When that sum
    // carries, the copy with 2^256 - p added gives the sum minus p below 2^256.
    always_comb begin
      top_bits  = acc_in[FIELD_W-1 -: FOLD_BITS];
      low_part  = {acc_in[FIELD_W-FOLD_BITS-1:0], lo_in[FIELD_W-1 -: FOLD_BITS]};
      sum_plain = {1'b0, low_part} + {1'b0, FOLD_TBL[top_bits]};
      sum_comp  = {1'b0, low_part} + {1'b0, FOLD_TBL_COMP[top_bits]};
      if (op_k != OP_MUL) begin
        acc_next = acc_in;
      end else if (sum_plain[FIELD_W]) begin
        acc_next = sum_comp[FIELD_W-1:0];
      end else begin
        acc_next = sum_plain[FIELD_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        r_valid[k] <= 1'b0;
      end else if (en) begin
        r_valid[k] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_acc[k] <= acc_next;
        r_lo[k]  <= {lo_in[FIELD_W-FOLD_BITS-1:0], {FOLD_BITS{1'b0}}};
        r_op[k]  <= op_k;
      end
    end
  end

  // The folded value is below 2^256 and so below 2p; one subtract finishes it.
  always_comb begin
    logic [FIELD_W:0] fin_sub;
    fin_sub = {1'b0, r_acc[RED_STAGES-1]} - {1'b0, PRIME_P};
    if (r_op[RED_STAGES-1] == OP_MUL && !fin_sub[FIELD_W]) begin
      out_next = fin_sub[FIELD_W-1:0];
    end else begin
      out_next = r_acc[RED_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= r_valid[RED_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= out_next;
      out_op  <= r_op[RED_STAGES-1];
    end
  end

  `PFA_ASSERT_NOW(a_mul_below_p, m_axis_tvalid && out_op == OP_MUL, m_axis_tdata < PRIME_P, "multiply result not below p")
  `PFA_ASSERT_NOW(a_unused_zero, m_axis_tvalid && out_op != OP_ADD && out_op != OP_SUB && out_op != OP_MUL, m_axis_tdata == '0, "unused operation gave nonzero result")
  `PFA_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")
  `PFA_ASSERT_NEXT(a_fold_bypass, en && r_valid[RED_STAGES/2-1] && r_op[RED_STAGES/2-1] != OP_MUL, r_acc[RED_STAGES/2] == $past(r_acc[RED_STAGES/2-1]), "add or subtract result changed in the fold stages")
  `PFA_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready, r_valid[RED_STAGES-1] == $past(r_valid[RED_STAGES-1]), "pipeline advanced during stall")

endmodule
`default_nettype wire
